[hdl/heading_pursuit_controller_core_macros.svh]
// Assertion macros shared by the heading pursuit controller RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef HEADING_PURSUIT_CONTROLLER_CORE_MACROS_SVH
`define HEADING_PURSUIT_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define HPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("hpc: invariant violated");
// Checks that a condition holds in the cycle after a trigger.
`define HPC_ASSERT_NEXT(label, clk, trig, cond) \
   label: assert property (@(posedge clk) (trig) |=> (cond)) \
      else $error("hpc: next-cycle check failed");
`else
`define HPC_ASSERT_ALWAYS(label, clk, rst, cond)
`define HPC_ASSERT_NEXT(label, clk, trig, cond)
`endif
`endif

[hdl/hpc_pkg.sv]
// Package for the heading pursuit controller: payload types, register codes,
// fixed-point constants and the arctangent table. Depends on nothing.
package hpc_pkg;

   // Default parameter values.
   localparam int HPC_CORDIC_STEPS    = 14;
   localparam int HPC_ANGLE_FRAC_BITS = 12;
   localparam int QUEUE_DEPTH         = 2;

   // CORDIC angle accumulator is Q30.
   localparam int ACC_FRAC_BITS = 30;
   localparam int Z_W           = 34;
   localparam int X_W           = 28;
   localparam logic signed [Z_W-1:0] PI_Q30    = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] SLACK_Q30 = 34'sd10737418;

   // Output rate limits.
   localparam int RATE_OUT_W = 20;
   localparam logic signed [RATE_OUT_W-1:0] RATE_MAX = 20'sd524287;
   localparam logic signed [RATE_OUT_W-1:0] RATE_MIN = -20'sd524288;

   // Opcodes of the input item.
   localparam logic OP_OWN_POSE    = 1'b0;
   localparam logic OP_TARGET_POSE = 1'b1;

   // Register indexes.
   localparam logic [1:0] REG_CRUISE_SPEED     = 2'd0;
   localparam logic [1:0] REG_TURN_GAIN        = 2'd1;
   localparam logic [1:0] REG_STOP_DISTANCE_SQ = 2'd2;
   localparam logic [1:0] REG_TURN_DEADBAND    = 2'd3;

   typedef struct packed {
      logic              opcode;
      logic signed [15:0] x_position;
      logic signed [15:0] y_position;
      logic signed [15:0] heading;
   } req_payload_type;

   typedef struct packed {
      logic [14:0]        linear_speed;
      logic signed [19:0] angular_rate;
   } rsp_payload_type;

   typedef struct packed {
      logic [14:0] cruise_speed;
      logic [3:0]  turn_gain;
      logic [15:0] stop_distance_sq;
      logic [11:0] turn_deadband;
   } cfg_type;

   // One target item with offsets already formed against the own pose.
   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [15:0] heading;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Arctangent of 2^-i in Q30.
   function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:  val = 34'sd843314857;
         5'd1:  val = 34'sd497837829;
         5'd2:  val = 34'sd263043837;
         5'd3:  val = 34'sd133525159;
         5'd4:  val = 34'sd67021687;
         5'd5:  val = 34'sd33543516;
         5'd6:  val = 34'sd16775851;
         5'd7:  val = 34'sd8388437;
         5'd8:  val = 34'sd4194283;
         5'd9:  val = 34'sd2097149;
         5'd10: val = 34'sd1048576;
         5'd11: val = 34'sd524288;
         5'd12: val = 34'sd262144;
         5'd13: val = 34'sd131072;
         5'd14: val = 34'sd65536;
         5'd15: val = 34'sd32768;
         5'd16: val = 34'sd16384;
         5'd17: val = 34'sd8192;
         5'd18: val = 34'sd4096;
         5'd19: val = 34'sd2048;
         5'd20: val = 34'sd1024;
         5'd21: val = 34'sd512;
         5'd22: val = 34'sd256;
         5'd23: val = 34'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[hdl/heading_pursuit_controller_core.sv]
// Heading pursuit controller top level: register port, front end, queue, back end.
// An own-pose item gives no result. A target item gives its result after the distance
// test when close, else after the iterative CORDIC (or the heading wrap, if longer).
// One target item is worked at a time; the queue keeps accepting until it is full.
// Synchronous active-high reset restores the register defaults and a zero own pose.
`include "heading_pursuit_controller_core_macros.svh"
module heading_pursuit_controller_core
   import hpc_pkg::*;
#(
   parameter int CORDIC_STEPS    = HPC_CORDIC_STEPS,
   parameter int ANGLE_FRAC_BITS = HPC_ANGLE_FRAC_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   job_type          push_job, head_job;
   logic             job_push, job_pop;
   logic             csr_write;

   // Register writes complete in the access phase.
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in     = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_CRUISE_SPEED:     cfg_in.cruise_speed     = csr_pwdata[14:0];
            REG_TURN_GAIN:        cfg_in.turn_gain        = csr_pwdata[3:0];
            REG_STOP_DISTANCE_SQ: cfg_in.stop_distance_sq = csr_pwdata[15:0];
            REG_TURN_DEADBAND:    cfg_in.turn_deadband    = csr_pwdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_CRUISE_SPEED:     csr_prdata = 32'(cfg_ff.cruise_speed);
         REG_TURN_GAIN:        csr_prdata = 32'(cfg_ff.turn_gain);
         REG_STOP_DISTANCE_SQ: csr_prdata = 32'(cfg_ff.stop_distance_sq);
         REG_TURN_DEADBAND:    csr_prdata = 32'(cfg_ff.turn_deadband);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_speed     <= 15'd256;
         cfg_ff.turn_gain        <= 4'd4;
         cfg_ff.stop_distance_sq <= 16'd655;
         cfg_ff.turn_deadband    <= 12'd41;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .job_push    (job_push),
      .job         (push_job)
   );

   hpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   hpc_back #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_valid   (!q_status.empty),
      .job         (head_job),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Queue and back end consistency checks.
   `HPC_ASSERT_ALWAYS(a_queue_status, clock, reset, !(q_status.full && q_status.empty))
   `HPC_ASSERT_ALWAYS(a_pop_nonempty, clock, reset, !job_pop || !q_status.empty)
   `HPC_ASSERT_ALWAYS(a_pop_not_busy, clock, reset, !(job_pop && rsp_valid))
   `HPC_ASSERT_NEXT(a_reset_clear, clock, reset, !rsp_valid && q_status.empty)

endmodule

[hdl/hpc_front.sv]
// Front end: accepts pose items, keeps the own pose and queues target jobs.
// Depends on hpc_pkg.
module hpc_front
   import hpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   input  queue_status_type q_status,
   output logic             job_push,
   output job_type          job
);

   logic signed [15:0] own_x_ff, own_x_in;
   logic signed [15:0] own_y_ff, own_y_in;
   logic signed [15:0] own_h_ff, own_h_in;
   logic               accept;

   // Stall while the job queue has no room.
   always_comb begin
      req_stall = q_status.full;
      accept    = req_valid && !req_stall;
      job_push  = accept && (req_payload.opcode == OP_TARGET_POSE);
      job.dx      = 17'(req_payload.x_position) - 17'(own_x_ff);
      job.dy      = 17'(req_payload.y_position) - 17'(own_y_ff);
      job.heading = own_h_ff;
   end

   // An own-pose transfer replaces the stored pose.
   always_comb begin
      own_x_in = own_x_ff;
      own_y_in = own_y_ff;
      own_h_in = own_h_ff;
      if (accept && (req_payload.opcode == OP_OWN_POSE)) begin
         own_x_in = req_payload.x_position;
         own_y_in = req_payload.y_position;
         own_h_in = req_payload.heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff <= '0;
         own_y_ff <= '0;
         own_h_ff <= '0;
      end else begin
         own_x_ff <= own_x_in;
         own_y_ff <= own_y_in;
         own_h_ff <= own_h_in;
      end
   end

endmodule

[hdl/hpc_queue.sv]
// Short job queue between the front end and the back end.
// Depends on hpc_pkg.
module hpc_queue
   import hpc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status and head of the queue.
   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CNT_W'(DEPTH));
      head_job     = mem_ff[rd_ptr_ff];
   end

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hdl/hpc_back.sv]
// Back end: distance test, iterative CORDIC bearing, heading wrap and rate law.
// Depends on hpc_pkg.
module hpc_back
   import hpc_pkg::*;
#(
   parameter int CORDIC_STEPS    = HPC_CORDIC_STEPS,
   parameter int ANGLE_FRAC_BITS = HPC_ANGLE_FRAC_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            job_valid,
   input  job_type         job,
   output logic            job_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int SHIFT  = ACC_FRAC_BITS - ANGLE_FRAC_BITS;
   localparam int CNT_W  = $clog2(CORDIC_STEPS + 1);
   localparam int H_W    = 20;
   localparam int ERR_W  = 21;
   localparam int RATE_W = 26;
   localparam longint PI_A    = (longint'(PI_Q30) + (longint'(1) << (SHIFT - 1))) >> SHIFT;
   localparam longint SLACK_A = (longint'(SLACK_Q30) + (longint'(1) << (SHIFT - 1))) >> SHIFT;
   localparam logic signed [H_W-1:0] WRAP_LIMIT = H_W'(PI_A + SLACK_A);
   localparam logic signed [H_W-1:0] TWO_PI     = H_W'(2 * PI_A);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SQUARE  = 3'd1;
   localparam logic [2:0] ST_COMPARE = 3'd2;
   localparam logic [2:0] ST_ITER    = 3'd3;
   localparam logic [2:0] ST_FINAL   = 3'd4;
   localparam logic [2:0] ST_SAT     = 3'd5;
   localparam logic [2:0] ST_OUT     = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic signed [16:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic signed [H_W-1:0]    h_ff, h_in;
   logic [33:0]              sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic signed [X_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic                     valid_ff, valid_in;
   logic [14:0]              speed_ff, speed_in;
   logic signed [19:0]       ang_ff, ang_in;

   logic [34:0]              dist_sq;
   logic signed [X_W-1:0]    xs, ys, x0, y0;
   logic signed [Z_W-1:0]    z_round, bearing;
   logic signed [ERR_W-1:0]  err;
   logic signed [RATE_W-1:0] deadband;
   logic                     cordic_active, wrap_active;

   // Shared datapath terms.
   always_comb begin
      dist_sq       = 35'(sqx_ff) + 35'(sqy_ff);
      xs            = x_ff >>> cnt_ff;
      ys            = y_ff >>> cnt_ff;
      x0            = X_W'(dx_ff) <<< 8;
      y0            = X_W'(dy_ff) <<< 8;
      cordic_active = (cnt_ff != CNT_W'(CORDIC_STEPS)) && (y_ff != '0);
      wrap_active   = (h_ff > WRAP_LIMIT) || (h_ff < -WRAP_LIMIT);
      z_round       = z_ff + (Z_W'(1) <<< (SHIFT - 1));
      bearing       = z_round >>> SHIFT;
      err           = ERR_W'(bearing) - ERR_W'(h_ff);
      deadband      = RATE_W'(signed'({1'b0, cfg.turn_deadband}));
   end

   // Sequencer for one target job.
   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      h_in     = h_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      rate_in  = rate_ff;
      valid_in = valid_ff;
      speed_in = speed_ff;
      ang_in   = ang_ff;
      job_pop  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               dx_in    = job.dx;
               dy_in    = job.dy;
               h_in     = H_W'(job.heading);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // Squares of the offsets, and the CORDIC start vector.
            sqx_in = 34'(dx_ff * dx_ff);
            sqy_in = 34'(dy_ff * dy_ff);
            cnt_in = '0;
            if (dx_ff < 0) begin
               x_in = -x0;
               y_in = -y0;
               z_in = (dy_ff >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
               x_in = x0;
               y_in = y0;
               z_in = '0;
            end
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (dist_sq < 35'(cfg.stop_distance_sq)) begin
               speed_in = '0;
               ang_in   = '0;
               valid_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            // CORDIC rotation and heading wrap run side by side.
            if (cordic_active) begin
               cnt_in = cnt_ff + 1'b1;
               if (y_ff > 0) begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + atan_q30(5'(cnt_ff));
               end else begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - atan_q30(5'(cnt_ff));
               end
            end
            if (h_ff > WRAP_LIMIT) begin
               h_in = h_ff - TWO_PI;
            end else if (h_ff < -WRAP_LIMIT) begin
               h_in = h_ff + TWO_PI;
            end
            if (!cordic_active && !wrap_active) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rate_in  = RATE_W'(err) * RATE_W'(signed'({1'b0, cfg.turn_gain}));
            state_in = ST_SAT;
         end
         ST_SAT: begin
            // Deadband first, then clamp to the output range.
            if ((rate_ff < deadband) && (rate_ff > -deadband)) begin
               ang_in = '0;
            end else if (rate_ff > RATE_W'(RATE_MAX)) begin
               ang_in = RATE_MAX;
            end else if (rate_ff < RATE_W'(RATE_MIN)) begin
               ang_in = RATE_MIN;
            end else begin
               ang_in = 20'(rate_ff);
            end
            speed_in = cfg.cruise_speed;
            valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      h_ff     <= h_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      cnt_ff   <= cnt_in;
      rate_ff  <= rate_in;
      speed_ff <= speed_in;
      ang_ff   <= ang_in;
   end

   assign rsp_valid                = valid_ff;
   assign rsp_payload.linear_speed = speed_ff;
   assign rsp_payload.angular_rate = ang_ff;

endmodule
